// File: rtl/esoa_pkg.sv
// Shared types, constants and the control store of the site-overlap amplitude block.
// Used by every module in this folder; it depends on nothing else.
`default_nettype none

package esoa_pkg;

    localparam int IDX_W      = 4;
    localparam int LEV_W      = 16;
    localparam int STR_W      = 32;
    localparam int SQ_W       = 31;
    localparam int PQ_W       = 62;
    localparam int PROD_W     = 64;
    localparam int TERM_W     = 48;
    localparam int AMP_W      = 48;
    localparam int ACC_W      = 52;
    localparam int SIZE_W     = 5;
    localparam int FRAC_SHIFT = 30;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = 1;
    localparam int FIFO_CNT_W = 2;

    typedef enum logic [1:0] {
        MODE_LOAD_EIG      = 2'd0,
        MODE_LOAD_STRENGTH = 2'd1,
        MODE_ROW_REQ       = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        CFG_SIZE             = 2'd0,
        CFG_UNIFORM_MODE     = 2'd1,
        CFG_UNIFORM_STRENGTH = 2'd2
    } cfg_reg_t;

    typedef enum logic [0:0] {
        PC_WAIT  = 1'b0,
        PC_ISSUE = 1'b1
    } pc_t;

    typedef enum logic [0:0] {
        COND_ROW_REQ  = 1'b0,
        COND_ROW_DONE = 1'b1
    } cond_t;

    typedef struct packed {
        logic  take_input;
        logic  issue;
        cond_t cond;
        pc_t   jump_pc;
        pc_t   fall_pc;
    } ucode_t;

    typedef struct packed {
        logic             issue;
        logic             first;
        logic             last_site;
        logic             last_col;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] site;
        logic             ld_eig;
        logic             ld_str;
    } ctrl_t;

    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last_site;
        logic             last_col;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } tag_t;

    typedef struct packed {
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [AMP_W-1:0] amp;
        logic                    last;
    } result_t;

    function automatic ucode_t ucode_rom(input pc_t pc);
        ucode_t word;
        unique case (pc)
            PC_WAIT:  word = '{take_input: 1'b1, issue: 1'b0, cond: COND_ROW_REQ,
                               jump_pc: PC_ISSUE, fall_pc: PC_WAIT};
            PC_ISSUE: word = '{take_input: 1'b0, issue: 1'b1, cond: COND_ROW_DONE,
                               jump_pc: PC_WAIT, fall_pc: PC_ISSUE};
        endcase
        return word;
    endfunction

endpackage

`default_nettype wire

// File: rtl/esoa_sequencer.sv
// Microcoded sequencer: program counter over the control store, row, column and site
// counters, and the credit count for the output buffer. Depends on esoa_pkg.
`default_nettype none

module esoa_sequencer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [1:0]                    in_mode,
    input  wire logic [esoa_pkg::IDX_W-1:0]    in_row,
    input  wire logic [esoa_pkg::SIZE_W-1:0]   n_used,
    input  wire logic                          out_take,
    output esoa_pkg::ctrl_t                    ctrl
);
    import esoa_pkg::*;

    pc_t                   pc_reg;
    pc_t                   pc_next;
    ucode_t                word;
    logic [IDX_W-1:0]      row_reg;
    logic [IDX_W-1:0]      row_next;
    logic [IDX_W-1:0]      col_reg;
    logic [IDX_W-1:0]      col_next;
    logic [IDX_W-1:0]      site_reg;
    logic [IDX_W-1:0]      site_next;
    logic [FIFO_CNT_W-1:0] credit_reg;
    logic [FIFO_CNT_W-1:0] credit_next;
    logic                  accept;
    logic                  req_ok;
    logic                  issue_fire;
    logic                  last_site;
    logic                  last_col;
    logic                  cond_true;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg     <= PC_WAIT;
            credit_reg <= '0;
            row_reg    <= '0;
            col_reg    <= '0;
            site_reg   <= '0;
        end
        else
        begin
            pc_reg     <= pc_next;
            credit_reg <= credit_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            site_reg   <= site_next;
        end
    end

    always_comb
    begin
        word       = ucode_rom(pc_reg);
        in_ready   = word.take_input;
        accept     = in_valid && word.take_input;
        req_ok     = accept && (mode_t'(in_mode) == MODE_ROW_REQ)
                     && ({1'b0, in_row} < n_used);
        issue_fire = word.issue
                     && ((site_reg != '0) || (credit_reg != FIFO_CNT_W'(FIFO_DEPTH)));
        last_site  = ({1'b0, site_reg} == (n_used - SIZE_W'(1)));
        last_col   = ({1'b0, col_reg} == (n_used - SIZE_W'(1)));

        unique case (word.cond)
            COND_ROW_REQ:  cond_true = req_ok;
            COND_ROW_DONE: cond_true = issue_fire && last_site && last_col;
        endcase
        pc_next = cond_true ? word.jump_pc : word.fall_pc;

        row_next  = row_reg;
        col_next  = col_reg;
        site_next = site_reg;
        if (req_ok)
        begin
            row_next  = in_row;
            col_next  = '0;
            site_next = '0;
        end
        else if (issue_fire)
        begin
            if (last_site)
            begin
                site_next = '0;
                col_next  = col_reg + IDX_W'(1);
            end
            else
            begin
                site_next = site_reg + IDX_W'(1);
            end
        end

        credit_next = credit_reg
                      + FIFO_CNT_W'(issue_fire && (site_reg == '0))
                      - FIFO_CNT_W'(out_take);

        ctrl.issue     = issue_fire;
        ctrl.first     = (site_reg == '0);
        ctrl.last_site = last_site;
        ctrl.last_col  = last_col;
        ctrl.row       = row_reg;
        ctrl.col       = col_reg;
        ctrl.site      = site_reg;
        ctrl.ld_eig    = accept && (mode_t'(in_mode) == MODE_LOAD_EIG);
        ctrl.ld_str    = accept && (mode_t'(in_mode) == MODE_LOAD_STRENGTH);
    end

endmodule

`default_nettype wire

// File: rtl/esoa_datapath.sv
// Eigenvector and strength stores and the pipelined multiply-accumulate that forms
// one amplitude per column. Depends on esoa_pkg.
`default_nettype none

module esoa_datapath #(
    parameter int MAX_SITES = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire esoa_pkg::ctrl_t              ctrl,
    input  wire logic [esoa_pkg::IDX_W-1:0]   ld_row,
    input  wire logic [esoa_pkg::IDX_W-1:0]   ld_col,
    input  wire logic [esoa_pkg::STR_W-1:0]   ld_value,
    input  wire logic                         uniform_mode,
    input  wire logic signed [esoa_pkg::STR_W-1:0] uniform_strength,
    output logic                              push,
    output esoa_pkg::result_t                 push_data
);
    import esoa_pkg::*;

    localparam int LIM   = (MAX_SITES < 16) ? MAX_SITES : 16;
    localparam int DEPTH = LIM * LIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = (LIM > 1) ? $clog2(LIM) : 1;

    logic signed [LEV_W-1:0] eig_mem [DEPTH];
    logic signed [STR_W-1:0] str_mem [LIM];

    logic [AW-1:0]           wr_addr;
    logic [AW-1:0]           addr_a;
    logic [AW-1:0]           addr_b;
    logic                    wr_in_range;

    tag_t                    tag_r_reg;
    tag_t                    tag_s_reg;
    tag_t                    tag_f_reg;
    tag_t                    tag_m_reg;
    tag_t                    tag_r_next;

    logic signed [LEV_W-1:0] la_reg;
    logic signed [LEV_W-1:0] lb_reg;
    logic signed [STR_W-1:0] str_reg;
    logic [SQ_W-1:0]         p_reg;
    logic [SQ_W-1:0]         q_reg;
    logic signed [STR_W-1:0] w_s_reg;
    logic [SQ_W-1:0]         f_reg;
    logic signed [STR_W-1:0] w_f_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    logic signed [2*LEV_W-1:0] sq_a;
    logic signed [2*LEV_W-1:0] sq_b;
    logic [PQ_W-1:0]           pq;
    logic signed [ACC_W-1:0]   term;
    logic                      sat;

    always_comb
    begin
        wr_addr     = AW'(({4'd0, ld_row} * 8'(LIM)) + {4'd0, ld_col});
        addr_a      = AW'(({4'd0, ctrl.row} * 8'(LIM)) + {4'd0, ctrl.site});
        addr_b      = AW'(({4'd0, ctrl.col} * 8'(LIM)) + {4'd0, ctrl.site});
        wr_in_range = (int'(ld_row) < MAX_SITES) && (int'(ld_col) < MAX_SITES);

        tag_r_next.valid     = ctrl.issue;
        tag_r_next.first     = ctrl.first;
        tag_r_next.last_site = ctrl.last_site;
        tag_r_next.last_col  = ctrl.last_col;
        tag_r_next.row       = ctrl.row;
        tag_r_next.col       = ctrl.col;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld_eig && wr_in_range)
        begin
            eig_mem[wr_addr] <= ld_value[LEV_W-1:0];
        end
        if (ctrl.ld_str && (int'(ld_col) < MAX_SITES))
        begin
            str_mem[SW'(ld_col)] <= ld_value;
        end
        la_reg  <= eig_mem[addr_a];
        lb_reg  <= eig_mem[addr_b];
        str_reg <= str_mem[SW'(ctrl.site)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_r_reg <= '0;
            tag_s_reg <= '0;
            tag_f_reg <= '0;
            tag_m_reg <= '0;
        end
        else
        begin
            tag_r_reg <= tag_r_next;
            tag_s_reg <= tag_r_reg;
            tag_f_reg <= tag_s_reg;
            tag_m_reg <= tag_f_reg;
        end
    end

    always_comb
    begin
        sq_a = (2*LEV_W)'(la_reg) * (2*LEV_W)'(la_reg);
        sq_b = (2*LEV_W)'(lb_reg) * (2*LEV_W)'(lb_reg);
        pq   = PQ_W'(p_reg) * PQ_W'(q_reg);
    end

    always_ff @(posedge clk)
    begin
        p_reg    <= sq_a[SQ_W-1:0];
        q_reg    <= sq_b[SQ_W-1:0];
        w_s_reg  <= uniform_mode ? uniform_strength : str_reg;
        f_reg    <= pq[FRAC_SHIFT+SQ_W-1:FRAC_SHIFT];
        w_f_reg  <= w_s_reg;
        prod_reg <= PROD_W'($signed({1'b0, f_reg})) * PROD_W'(w_f_reg);
    end

    always_comb
    begin
        term     = {{(ACC_W-TERM_W){prod_reg[PROD_W-1]}}, prod_reg[PROD_W-1:PROD_W-TERM_W]};
        acc_next = (tag_m_reg.first ? ACC_W'(0) : acc_reg) + term;
        sat      = !((&acc_next[ACC_W-1:AMP_W-1]) || !(|acc_next[ACC_W-1:AMP_W-1]));

        push          = tag_m_reg.valid && tag_m_reg.last_site;
        push_data.row = tag_m_reg.row;
        push_data.col = tag_m_reg.col;
        push_data.last = tag_m_reg.last_col;
        if (sat)
        begin
            push_data.amp = acc_next[ACC_W-1] ? {1'b1, {(AMP_W-1){1'b0}}}
                                              : {1'b0, {(AMP_W-1){1'b1}}};
        end
        else
        begin
            push_data.amp = acc_next[AMP_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag_m_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/esoa_out_fifo.sv
// Two-word output buffer between the accumulator and the result stream.
// Depends on esoa_pkg.
`default_nettype none

module esoa_out_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire esoa_pkg::result_t push_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output esoa_pkg::result_t      out_data
);
    import esoa_pkg::*;

    result_t               mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic                  pop;

    always_comb
    begin
        out_valid = (count_reg != '0);
        out_data  = mem[rd_ptr_reg];
        pop       = out_valid && out_ready;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(push);
            rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(pop);
            count_reg  <= count_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
        end
    end

endmodule

`default_nettype wire

// File: rtl/exciton_site_overlap_amplitudes_core.sv
// A row request for N states issues N*N site products through the shared
// multiply-accumulate, one per cycle while the output buffer has credit; the input is ready
// again in the cycle after the last one issues. The two-word buffer holds issue back while
// two words are in flight or unread, so a slow receiver or a very small N adds
// stall cycles. Reset sets size to 16, uniform mode on and strength 1.0, and empties the
// sequencer, pipeline and output buffer; the stores are not cleared.
`default_nettype none

module exciton_site_overlap_amplitudes_core #(
    parameter int MAX_SITES = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // row_index, column_index, element_value
    input  wire logic [1:0]  s_tuser,   // mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // result_row, result_column, amplitude
    output logic             m_tlast,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import esoa_pkg::*;

    localparam int LIM = (MAX_SITES < 16) ? MAX_SITES : 16;

    logic [SIZE_W-1:0]       size_reg;
    logic                    uniform_mode_reg;
    logic signed [STR_W-1:0] uniform_strength_reg;
    logic [SIZE_W-1:0]       n_used;
    ctrl_t                   ctrl;
    logic                    push;
    result_t                 push_data;
    result_t                 out_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg             <= SIZE_W'(16);
            uniform_mode_reg     <= 1'b1;
            uniform_strength_reg <= STR_W'(65536);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_SIZE:             size_reg             <= cfg_data[SIZE_W-1:0];
                CFG_UNIFORM_MODE:     uniform_mode_reg     <= cfg_data[0];
                CFG_UNIFORM_STRENGTH: uniform_strength_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        if (size_reg == '0)
        begin
            n_used = SIZE_W'(1);
        end
        else if (size_reg > SIZE_W'(LIM))
        begin
            n_used = SIZE_W'(LIM);
        end
        else
        begin
            n_used = size_reg;
        end
    end

    esoa_sequencer u_sequencer (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_mode  (s_tuser),
        .in_row   (s_tdata[3:0]),
        .n_used   (n_used),
        .out_take (m_tvalid && m_tready),
        .ctrl     (ctrl)
    );

    esoa_datapath #(
        .MAX_SITES (MAX_SITES)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctrl             (ctrl),
        .ld_row           (s_tdata[3:0]),
        .ld_col           (s_tdata[7:4]),
        .ld_value         (s_tdata[39:8]),
        .uniform_mode     (uniform_mode_reg),
        .uniform_strength (uniform_strength_reg),
        .push             (push),
        .push_data        (push_data)
    );

    esoa_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {out_data.amp, out_data.col, out_data.row};
    assign m_tlast = out_data.last;

endmodule

`default_nettype wire
